### sv/timed_register_write_player_macros.svh
// Assertion macros shared by the timed register write player RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TIMED_REGISTER_WRITE_PLAYER_MACROS_SVH
`define TIMED_REGISTER_WRITE_PLAYER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TRWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define TRWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TRWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TRWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/trwp_pkg.sv
// Types and constants of the timed register write player.
// No dependencies; used by the interfaces, the step logic and the top level.
package trwp_pkg;

    localparam int OPCODE_W   = 2;
    localparam int STAMP_W    = 32;
    localparam int REG_W      = 5;
    localparam int DATA_W     = 8;
    localparam int STAT_W     = 32;
    localparam int GAP_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Untimed writes go out at once when now is within this many ticks of the top.
    localparam int NEAR_TOP_SPAN = 16;

    localparam logic [STAT_W-1:0] STAT_MAX  = '1;
    localparam logic [GAP_W-1:0]  GAP_RESET = 8'd3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_SONG  = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATS_ENABLE = 1'b0,
        CFG_UNTIMED_GAP  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [STAMP_W-1:0]  timestamp;
        logic [REG_W-1:0]    reg_addr;
        logic [DATA_W-1:0]   reg_value;
        logic                untimed;
    } item_t;

    typedef struct packed {
        logic              write_valid;
        logic [REG_W-1:0]  write_reg;
        logic [DATA_W-1:0] write_data;
        logic              was_late;
        logic              refused;
        logic              busy_res;
        logic [STAT_W-1:0] max_delay;
        logic [STAT_W-1:0] start_late_count;
        logic [STAT_W-1:0] other_late_count;
    } result_t;

    typedef struct packed {
        logic             stats_enable;
        logic [GAP_W-1:0] untimed_gap;
    } cfg_t;

endpackage

### sv/trwp_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on trwp_pkg for field widths.
interface trwp_in_if;
    logic                          valid;
    logic                          ready;
    logic [trwp_pkg::OPCODE_W-1:0] opcode;
    logic [trwp_pkg::STAMP_W-1:0]  timestamp;
    logic [trwp_pkg::REG_W-1:0]    reg_addr;
    logic [trwp_pkg::DATA_W-1:0]   reg_value;
    logic                          untimed;

    modport source (output valid, opcode, timestamp, reg_addr, reg_value, untimed,
                    input ready);
    modport sink   (input valid, opcode, timestamp, reg_addr, reg_value, untimed,
                    output ready);
endinterface

interface trwp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        write_valid;
    logic [trwp_pkg::REG_W-1:0]  write_reg;
    logic [trwp_pkg::DATA_W-1:0] write_data;
    logic                        was_late;
    logic                        refused;
    logic                        busy_res;
    logic [trwp_pkg::STAT_W-1:0] max_delay;
    logic [trwp_pkg::STAT_W-1:0] start_late_count;
    logic [trwp_pkg::STAT_W-1:0] other_late_count;

    modport source (output valid, write_valid, write_reg, write_data, was_late, refused,
                    busy_res, max_delay, start_late_count, other_late_count,
                    input ready);
    modport sink   (input valid, write_valid, write_reg, write_data, was_late, refused,
                    busy_res, max_delay, start_late_count, other_late_count,
                    output ready);
endinterface

### sv/trwp_step.sv
// Player state (time base, pending write, statistics) and its one-pass update.
// Depends on trwp_pkg for item, result and configuration types.
module trwp_step #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  trwp_pkg::item_t   item,
    input  trwp_pkg::cfg_t    cfg,
    output trwp_pkg::result_t result
);

    localparam logic [TIME_BITS-1:0] NEAR_TOP =
        ~TIME_BITS'(trwp_pkg::NEAR_TOP_SPAN - 1);

    logic [TIME_BITS-1:0]        now_reg, now_next;
    logic [TIME_BITS-1:0]        now_p1_reg, now_p1_next;
    logic [TIME_BITS-1:0]        base_reg, base_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [TIME_BITS-1:0]        pend_due_reg, pend_due_next;
    logic [trwp_pkg::REG_W-1:0]  pend_reg_reg, pend_reg_next;
    logic [trwp_pkg::DATA_W-1:0] pend_data_reg, pend_data_next;
    logic [TIME_BITS-1:0]        max_reg, max_next;
    logic [trwp_pkg::STAT_W-1:0] start_reg, start_next;
    logic [trwp_pkg::STAT_W-1:0] other_reg, other_next;

    logic [TIME_BITS-1:0]        ts_eff;
    logic [TIME_BITS-1:0]        base_eff;
    logic [TIME_BITS-1:0]        due;
    logic [TIME_BITS:0]          diff_ext;
    logic [TIME_BITS-1:0]        diff;
    logic                        is_late;
    logic                        on_time;
    logic [TIME_BITS:0]          gap_sum;
    logic                        untimed_now;
    logic                        start_hit;
    logic [TIME_BITS-1:0]        late_base;
    logic                        tick_hit;
    logic [trwp_pkg::STAT_W-1:0] max_sat;

    logic                        wr_valid;
    logic [trwp_pkg::REG_W-1:0]  wr_reg;
    logic [trwp_pkg::DATA_W-1:0] wr_data;
    logic                        wr_late;
    logic                        wr_refused;

    assign ts_eff    = TIME_BITS'(item.timestamp);
    // An unsynced base syncs to now+1 on the first timed entry.
    assign base_eff  = (base_reg == '0) ? now_p1_reg : base_reg;
    assign due       = ts_eff + base_eff;
    assign diff_ext  = {1'b0, now_reg} - {1'b0, due};
    assign diff      = diff_ext[TIME_BITS-1:0];
    assign is_late   = !diff_ext[TIME_BITS] && (diff != '0);
    assign on_time   = (diff_ext == '0);
    assign gap_sum   = {1'b0, now_reg} + (TIME_BITS + 1)'(cfg.untimed_gap);
    assign untimed_now = (cfg.untimed_gap == '0) || (now_reg >= NEAR_TOP) ||
                         gap_sum[TIME_BITS];
    assign start_hit = (base_eff <= now_p1_reg);
    // base + lateness + 1 reduces to now + 1 - timestamp.
    assign late_base = now_p1_reg - ts_eff;
    assign tick_hit  = pend_valid_reg && (now_p1_reg >= pend_due_reg);

    always_comb
    begin
        now_next        = now_reg;
        now_p1_next     = now_p1_reg;
        base_next       = base_reg;
        pend_valid_next = pend_valid_reg;
        pend_due_next   = pend_due_reg;
        pend_reg_next   = pend_reg_reg;
        pend_data_next  = pend_data_reg;
        max_next        = max_reg;
        start_next      = start_reg;
        other_next      = other_reg;
        wr_valid        = 1'b0;
        wr_reg          = '0;
        wr_data         = '0;
        wr_late         = 1'b0;
        wr_refused      = 1'b0;

        unique case (item.opcode)
            trwp_pkg::OP_TICK:
            begin
                now_next    = now_p1_reg;
                now_p1_next = now_p1_reg + 1'b1;
                if (tick_hit)
                begin
                    wr_valid        = 1'b1;
                    wr_reg          = pend_reg_reg;
                    wr_data         = pend_data_reg;
                    pend_valid_next = 1'b0;
                end
            end
            trwp_pkg::OP_ENTRY:
            begin
                if (pend_valid_reg)
                begin
                    wr_refused = 1'b1;
                end
                else if (item.untimed)
                begin
                    if (untimed_now)
                    begin
                        wr_valid = 1'b1;
                        wr_reg   = item.reg_addr;
                        wr_data  = item.reg_value;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_due_next   = gap_sum[TIME_BITS-1:0];
                        pend_reg_next   = item.reg_addr;
                        pend_data_next  = item.reg_value;
                    end
                end
                else
                begin
                    base_next = base_eff;
                    if (is_late)
                    begin
                        if (cfg.stats_enable)
                        begin
                            if (diff > max_reg)
                            begin
                                max_next = diff;
                            end
                            if (start_hit)
                            begin
                                start_next = (start_reg == trwp_pkg::STAT_MAX) ?
                                             start_reg : start_reg + 1'b1;
                            end
                            else
                            begin
                                other_next = (other_reg == trwp_pkg::STAT_MAX) ?
                                             other_reg : other_reg + 1'b1;
                            end
                        end
                        base_next = late_base;
                        wr_late   = 1'b1;
                        wr_valid  = 1'b1;
                        wr_reg    = item.reg_addr;
                        wr_data   = item.reg_value;
                    end
                    else if (on_time)
                    begin
                        wr_valid = 1'b1;
                        wr_reg   = item.reg_addr;
                        wr_data  = item.reg_value;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_due_next   = due;
                        pend_reg_next   = item.reg_addr;
                        pend_data_next  = item.reg_value;
                    end
                end
            end
            trwp_pkg::OP_SONG:
            begin
                base_next       = '0;
                pend_valid_next = 1'b0;
                max_next        = '0;
                start_next      = '0;
                other_next      = '0;
            end
            default:
            begin
                // unused opcode: report status only
            end
        endcase
    end

    if (TIME_BITS > trwp_pkg::STAT_W)
    begin : g_sat_wide
        assign max_sat = (|max_next[TIME_BITS-1:trwp_pkg::STAT_W]) ? trwp_pkg::STAT_MAX :
                         max_next[trwp_pkg::STAT_W-1:0];
    end
    else
    begin : g_sat_narrow
        assign max_sat = trwp_pkg::STAT_W'(max_next);
    end

    assign result.write_valid      = wr_valid;
    assign result.write_reg        = wr_reg;
    assign result.write_data       = wr_data;
    assign result.was_late         = wr_late;
    assign result.refused          = wr_refused;
    assign result.busy_res         = pend_valid_next;
    assign result.max_delay        = max_sat;
    assign result.start_late_count = start_next;
    assign result.other_late_count = other_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            now_p1_reg     <= TIME_BITS'(1);
            base_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_due_reg   <= '0;
            pend_reg_reg   <= '0;
            pend_data_reg  <= '0;
            max_reg        <= '0;
            start_reg      <= '0;
            other_reg      <= '0;
        end
        else if (fire)
        begin
            now_reg        <= now_next;
            now_p1_reg     <= now_p1_next;
            base_reg       <= base_next;
            pend_valid_reg <= pend_valid_next;
            pend_due_reg   <= pend_due_next;
            pend_reg_reg   <= pend_reg_next;
            pend_data_reg  <= pend_data_next;
            max_reg        <= max_next;
            start_reg      <= start_next;
            other_reg      <= other_next;
        end
    end

endmodule

### sv/timed_register_write_player.sv
// Top level of the timed register write player: channels, configuration, pipeline.
// Depends on trwp_pkg, trwp_if, trwp_step and the assertion macro header.

// The player takes one item per clock while the result side keeps up and returns
// exactly one result for each: the item first lands in an input register,
// then a single combinational pass of trwp_step (one add for the due time, one
// subtract and compare for lateness, one compare against the pending due time)
// updates the player state and fills the result register. Both registers advance
// together, so a full pipeline keeps running at one item per cycle as long as the
// result side takes one result per cycle; a stall on the result side backs up into
// the input register and then drops ready. Tick items advance the microsecond
// count, entry items either write now, write late (and shift the base), park as
// the one pending write, or are refused while a write is pending, and a new-song
// item clears the base, the pending write and the statistics. The two configuration
// registers (statistics enable, untimed gap) are written through the plain write
// port and should only be changed while no items are in flight. There is no
// clearing pass after reset.
`include "timed_register_write_player_macros.svh"

module timed_register_write_player #(
    parameter int TIME_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    trwp_in_if.sink                           in_ch,
    trwp_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [trwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trwp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration registers.
    trwp_pkg::cfg_t    cfg_reg, cfg_next;

    // Input stage: one held item.
    logic              s1_valid_reg, s1_valid_next;
    trwp_pkg::item_t   s1_item_reg, s1_item_next;

    // Result stage.
    logic              out_valid_reg, out_valid_next;
    trwp_pkg::result_t out_res_reg, out_res_next;

    trwp_pkg::item_t   in_item;
    trwp_pkg::result_t step_res;
    logic              in_fire;
    logic              out_load;

    // Gather the input payload into one word.
    assign in_item.opcode    = in_ch.opcode;
    assign in_item.timestamp = in_ch.timestamp;
    assign in_item.reg_addr  = in_ch.reg_addr;
    assign in_item.reg_value = in_ch.reg_value;
    assign in_item.untimed   = in_ch.untimed;

    // Advance the held item into the result register whenever that register is
    // free or its contents are being taken in this cycle.
    assign out_load    = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    // Take a new item whenever the input register empties or moves on.
    assign in_ch.ready = !s1_valid_reg || out_load;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Apply the item to the player state exactly once, when it moves to the result.
    trwp_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (out_load),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (step_res)
    );

    // Configuration write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                trwp_pkg::CFG_STATS_ENABLE: cfg_next.stats_enable = cfg_wdata[0];
                trwp_pkg::CFG_UNTIMED_GAP:  cfg_next.untimed_gap  =
                                                cfg_wdata[trwp_pkg::GAP_W-1:0];
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Pipeline control: hold, advance or drain each stage.
    always_comb
    begin
        s1_item_next  = s1_item_reg;
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_item_next  = in_item;
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_res_next   = step_res;
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stats_enable <= 1'b1;
            cfg_reg.untimed_gap  <= trwp_pkg::GAP_RESET;
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        out_res_reg <= out_res_next;
    end

    // Drive the result channel from the result register.
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.write_valid      = out_res_reg.write_valid;
    assign out_ch.write_reg        = out_res_reg.write_reg;
    assign out_ch.write_data       = out_res_reg.write_data;
    assign out_ch.was_late         = out_res_reg.was_late;
    assign out_ch.refused          = out_res_reg.refused;
    assign out_ch.busy_res         = out_res_reg.busy_res;
    assign out_ch.max_delay        = out_res_reg.max_delay;
    assign out_ch.start_late_count = out_res_reg.start_late_count;
    assign out_ch.other_late_count = out_res_reg.other_late_count;

    // A late entry always issues its write.
    `TRWP_ASSERT_IMP(a_late_has_write, clk, rst_n,
        out_valid_reg && out_res_reg.was_late, out_res_reg.write_valid)
    // A refused entry never issues a write.
    `TRWP_ASSERT_IMP(a_refused_no_write, clk, rst_n,
        out_valid_reg && out_res_reg.refused, !out_res_reg.write_valid)
    // Without a write the register and data fields read as zero.
    `TRWP_ASSERT_IMP(a_idle_fields_zero, clk, rst_n,
        out_valid_reg && !out_res_reg.write_valid,
        (out_res_reg.write_reg == '0) && (out_res_reg.write_data == '0))
    // Ready drops only while an item is held in the input stage.
    `TRWP_ASSERT_IMP(a_ready_low_held, clk, rst_n, !in_ch.ready, s1_valid_reg)
    // A held item that cannot advance is still held next cycle.
    `TRWP_ASSERT_NXT(a_stall_keeps_item, clk, rst_n,
        s1_valid_reg && !out_load, s1_valid_reg)

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the timed register write player.
// Depends on trwp_pkg, trwp_if and timed_register_write_player; drives both
// channels, predicts every result in-line and checks results in order.
`timescale 1ns / 100ps

module tb_top;
    import trwp_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 11;
    localparam int          TAIL_CYCLES    = 8;     // the player pipeline is two stages deep
    localparam int          WATCHDOG_LIMIT = 4000;  // cycles without any transfer
    localparam int          LONG_HOLD      = 300;   // receiver hold-off for back-pressure
    localparam int          RANDOM_PER_PH  = 76;
    localparam int          PRINT_CAP      = 50;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [31:0] UNTIMED_CUTOFF = 32'hFFFF_FFFF - (NEAR_TOP_SPAN - 1);

    typedef struct {
        item_t   it;
        bit      typed;   // use the written-out result instead of the prediction
        result_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    trwp_in_if  in_ch ();
    trwp_out_if out_ch ();

    timed_register_write_player DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // Player state as the bench sees it; advanced once per accepted transfer.
    logic [31:0]       now_us         = '0;
    logic [31:0]       song_base      = '0;   // zero while the song is not synced
    logic              park_valid     = 1'b0;
    logic [31:0]       park_due       = '0;
    logic [REG_W-1:0]  park_reg       = '0;
    logic [DATA_W-1:0] park_data      = '0;
    logic [31:0]       worst_lateness = '0;
    logic [31:0]       start_late_n   = '0;
    logic [31:0]       other_late_n   = '0;
    logic              stats_on       = 1'b1;
    logic [GAP_W-1:0]  gap_us         = GAP_RESET;

    result_t   expected_results[$];
    step_row_t directed_rows[$];

    int  send_idle_pct = 32;
    int  recv_idle_pct = 82;
    bit  stall_request = 1'b0;
    int  hold_left     = 0;
    int  n_errors      = 0;
    int  n_items       = 0;
    int  n_writes      = 0;
    int  n_late        = 0;
    int  n_refused     = 0;
    int  quiet_cycles  = 0;

    function automatic item_t mk_item(logic [1:0] op, logic [31:0] stamp,
                                      logic [REG_W-1:0] rg, logic [DATA_W-1:0] val,
                                      logic untimed);
        item_t it;
        it.opcode    = op;
        it.timestamp = stamp;
        it.reg_addr  = rg;
        it.reg_value = val;
        it.untimed   = untimed;
        return it;
    endfunction

    function automatic result_t mk_res(logic wv, logic [REG_W-1:0] rg,
                                       logic [DATA_W-1:0] val, logic late, logic refd,
                                       logic busy, logic [31:0] maxd, logic [31:0] sl,
                                       logic [31:0] ol);
        result_t r;
        r.write_valid      = wv;
        r.write_reg        = rg;
        r.write_data       = val;
        r.was_late         = late;
        r.refused          = refd;
        r.busy_res         = busy;
        r.max_delay        = maxd;
        r.start_late_count = sl;
        r.other_late_count = ol;
        return r;
    endfunction

    // Advance the player state by one item and return the result it produces.
    function automatic result_t play_step(item_t it);
        result_t     r;
        logic [31:0] due;
        logic [31:0] lateness;
        logic [31:0] now_plus1;
        logic [31:0] headroom;
        r = '0;
        case (it.opcode)
            OP_TICK:
            begin
                // time moves first, then the parked write may fall due
                now_us = now_us + 32'd1;
                if (park_valid && now_us >= park_due)
                begin
                    r.write_valid = 1'b1;
                    r.write_reg   = park_reg;
                    r.write_data  = park_data;
                    park_valid    = 1'b0;
                end
            end
            OP_ENTRY:
            begin
                headroom = 32'hFFFF_FFFF - 32'(gap_us);
                if (park_valid)
                    r.refused = 1'b1;
                else if (it.untimed)
                begin
                    // untimed writes never touch the base and are never late
                    if (gap_us == '0 || now_us >= UNTIMED_CUTOFF || now_us > headroom)
                    begin
                        r.write_valid = 1'b1;
                        r.write_reg   = it.reg_addr;
                        r.write_data  = it.reg_value;
                    end
                    else
                    begin
                        park_valid = 1'b1;
                        park_due   = now_us + 32'(gap_us);
                        park_reg   = it.reg_addr;
                        park_data  = it.reg_value;
                    end
                end
                else
                begin
                    now_plus1 = now_us + 32'd1;
                    if (song_base == '0)
                        song_base = now_plus1;
                    due = it.timestamp + song_base;
                    if (now_us > due)
                    begin
                        lateness = now_us - due;
                        if (stats_on)
                        begin
                            if (lateness > worst_lateness)
                                worst_lateness = lateness;
                            if (song_base <= now_plus1)
                            begin
                                if (start_late_n != STAT_MAX)
                                    start_late_n = start_late_n + 32'd1;
                            end
                            else if (other_late_n != STAT_MAX)
                                other_late_n = other_late_n + 32'd1;
                        end
                        // push the base later so the song catches up with now
                        song_base     = song_base + lateness + 32'd1;
                        r.was_late    = 1'b1;
                        r.write_valid = 1'b1;
                        r.write_reg   = it.reg_addr;
                        r.write_data  = it.reg_value;
                    end
                    else if (now_us == due)
                    begin
                        r.write_valid = 1'b1;
                        r.write_reg   = it.reg_addr;
                        r.write_data  = it.reg_value;
                    end
                    else
                    begin
                        park_valid = 1'b1;
                        park_due   = due;
                        park_reg   = it.reg_addr;
                        park_data  = it.reg_value;
                    end
                end
            end
            OP_SONG:
            begin
                // new song: drop the base, the parked write and the statistics
                song_base      = '0;
                park_valid     = 1'b0;
                worst_lateness = '0;
                start_late_n   = '0;
                other_late_n   = '0;
            end
            default:
            begin
            end
        endcase
        r.busy_res         = park_valid;
        r.max_delay        = worst_lateness;
        r.start_late_count = start_late_n;
        r.other_late_count = other_late_n;
        return r;
    endfunction

    // Build a random item. Most entries are timed close to now on the current
    // song so that due, late and parked writes all come up; the rest carry a
    // full random timestamp or are ticks, new songs and unused opcodes.
    function automatic item_t next_stimulus();
        item_t       it;
        int          pick;
        int          delta;
        logic [31:0] rel;
        it.opcode    = OP_TICK;
        it.timestamp = $urandom();
        it.reg_addr  = REG_W'($urandom_range(31));
        it.reg_value = DATA_W'($urandom_range(255));
        it.untimed   = 1'($urandom_range(1));
        delta        = 0;
        pick = $urandom_range(99);
        if (pick < 40)
            it.opcode = OP_TICK;
        else if (pick < 43)
            it.opcode = OP_UNUSED;
        else if (pick < 47)
            it.opcode = OP_SONG;
        else
        begin
            it.opcode  = OP_ENTRY;
            it.untimed = ($urandom_range(99) < 15);
            // position of now on the song; an unsynced song syncs to now+1
            rel  = (song_base == '0) ? '1 : now_us - song_base;
            pick = $urandom_range(99);
            if (pick < 70)
                delta = int'($urandom_range(7)) - 3;
            else if (pick < 82)
                delta = -int'($urandom_range(2000, 4));
            else if (pick < 92)
                delta = int'($urandom_range(40, 5));
            if (pick < 92)
                it.timestamp = rel + 32'(delta);
        end
        return it;
    endfunction

    task automatic add_row(item_t it, bit typed, result_t want);
        directed_rows.push_back('{it, typed, want});
    endtask

    task automatic report_mismatch(string msg);
        n_errors++;
        // keep the log short when the block is badly off
        if (n_errors <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Offer one item at the falling edge and hold it until a transfer happens,
    // then log its expected result. Returns at a falling edge.
    task automatic push_item(item_t it, bit typed, result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.opcode    = it.opcode;
        in_ch.timestamp = it.timestamp;
        in_ch.reg_addr  = it.reg_addr;
        in_ch.reg_value = it.reg_value;
        in_ch.untimed   = it.untimed;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = play_step(it);
        expected_results.push_back(typed ? want : predicted);
        n_items++;
        @(negedge clk);
    endtask

    // Drop valid, let every outstanding result come back, then let the
    // pipeline settle. Returns at a falling edge.
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register while the block is idle. Starts and ends at a falling edge.
    task automatic write_cfg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_STATS_ENABLE: stats_on = value[0];
            CFG_UNTIMED_GAP:  gap_us   = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic run_phase(logic stats, logic [GAP_W-1:0] gap, int send_pct,
                             int recv_pct, bit squeeze);
        write_cfg(CFG_STATS_ENABLE, CFG_DATA_W'(stats));
        write_cfg(CFG_UNTIMED_GAP, gap);
        // change idling away from the falling edge the receiver acts on
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stall_request = squeeze;
        @(negedge clk);
        repeat (RANDOM_PER_PH) push_item(next_stimulus(), 1'b0, '0);
        wait_drained();
    endtask

    // Receiver: idle at random, or hold ready low for a long counted stretch
    // when asked, so the block fills up and stalls its input.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: compare each transfer with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.write_valid      = out_ch.write_valid;
            got.write_reg        = out_ch.write_reg;
            got.write_data       = out_ch.write_data;
            got.was_late         = out_ch.was_late;
            got.refused          = out_ch.refused;
            got.busy_res         = out_ch.busy_res;
            got.max_delay        = out_ch.max_delay;
            got.start_late_count = out_ch.start_late_count;
            got.other_late_count = out_ch.other_late_count;
            n_writes  += (got.write_valid === 1'b1);
            n_late    += (got.was_late === 1'b1);
            n_refused += (got.refused === 1'b1);
            if (expected_results.size() == 0)
                report_mismatch("result transfer with no item outstanding");
            else
            begin
                want = expected_results.pop_front();
                check_field("write_valid", 32'(got.write_valid), 32'(want.write_valid));
                check_field("write_reg", 32'(got.write_reg), 32'(want.write_reg));
                check_field("write_data", 32'(got.write_data), 32'(want.write_data));
                check_field("was_late", 32'(got.was_late), 32'(want.was_late));
                check_field("refused", 32'(got.refused), 32'(want.refused));
                check_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                check_field("max_delay", got.max_delay, want.max_delay);
                check_field("start_late_count", got.start_late_count,
                            want.start_late_count);
                check_field("other_late_count", got.other_late_count,
                            want.other_late_count);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_TICK;
        in_ch.timestamp = '0;
        in_ch.reg_addr  = '0;
        in_ch.reg_value = '0;
        in_ch.untimed   = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_STATS_ENABLE;
        cfg_wdata       = '0;

        // Directed table, run on the reset settings (statistics on, gap 3).
        // After reset: a tick issues nothing and an unused opcode changes nothing.
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_UNUSED, '1, '1, '1, 1'b1), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        // first timed entry syncs the base to now+1 and parks
        add_row(mk_item(OP_ENTRY, '0, 5'd31, 8'hFF, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 1, 0, 0, 0));
        // entry while a write is parked is refused
        add_row(mk_item(OP_ENTRY, 32'd5, 5'd0, 8'h00, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 1, 1, 0, 0, 0));
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(1, 31, 8'hFF, 0, 0, 0, 0, 0, 0));
        // due exactly now: written at once, not late
        add_row(mk_item(OP_ENTRY, '0, 5'd1, 8'h01, 1'b0), 1'b1,
                mk_res(1, 1, 8'h01, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        // two microseconds late right after the sync: a start-late entry
        add_row(mk_item(OP_ENTRY, '0, 5'd2, 8'h55, 1'b0), 1'b1,
                mk_res(1, 2, 8'h55, 1, 0, 0, 2, 1, 0));
        // largest timestamp wraps the due time back onto now
        add_row(mk_item(OP_ENTRY, '1, 5'd3, 8'hAA, 1'b0), 1'b1,
                mk_res(1, 3, 8'hAA, 0, 0, 0, 2, 1, 0));
        // wrapped late entries, then one late against a shifted base
        add_row(mk_item(OP_ENTRY, 32'hFFFF_FFFE, 5'd6, 8'h0F, 1'b0), 1'b0, '0);
        add_row(mk_item(OP_ENTRY, 32'hFFFF_FFF9, 5'd7, 8'hF0, 1'b0), 1'b0, '0);
        // new song clears the statistics
        add_row(mk_item(OP_SONG, '1, '1, '1, 1'b1), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        // untimed entry waits the gap, whatever its timestamp says
        add_row(mk_item(OP_ENTRY, '1, 5'd4, 8'h12, 1'b1), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 1, 0, 0, 0));
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 1, 0, 0, 0));
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 1, 0, 0, 0));
        add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                mk_res(1, 4, 8'h12, 0, 0, 0, 0, 0, 0));
        // new song drops a parked write; it never issues
        add_row(mk_item(OP_ENTRY, '0, 5'd5, 8'h34, 1'b1), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 1, 0, 0, 0));
        add_row(mk_item(OP_SONG, '0, '0, '0, 1'b0), 1'b1,
                mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        repeat (3)
            add_row(mk_item(OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                    mk_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // Random phases: walk the register extremes while the idling moves
        // from a slow receiver, to a slow sender, to no idling at all. The
        // fourth phase holds the receiver off long enough to back up the input.
        run_phase(1'b0, 8'd0,   32, 82, 1'b0);
        run_phase(1'b1, 8'd255, 82, 32, 1'b0);
        run_phase(1'b0, 8'd1,   82, 32, 1'b0);
        run_phase(1'b1, 8'd5,    0,  0, 1'b1);
        run_phase(1'b1, 8'd3,    0,  0, 1'b0);

        $display("run covered %0d items over six settings phases: %0d writes issued,",
                 n_items, n_writes);
        $display("%0d of them late, %0d entries refused, %0d mismatches",
                 n_late, n_refused, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
